// ----- src/swg_pkg.sv -----
// Shared types, constants and the quarter-wave sine table builder for the
// sine/triangle waveform generator. No dependencies.
package swg_pkg;

    localparam int PHASE_BITS    = 32;
    localparam int LEVEL_BITS    = 16;
    localparam int TBL_ADDR_BITS = 10;
    localparam int SINE_N        = 1 << TBL_ADDR_BITS;
    localparam int TOP_BITS      = 16;              // phase bits kept after the accumulator
    localparam int WAVE_BITS     = 17;              // Q1.15 wave with +1.0 reachable
    localparam int STEP_BITS     = 32;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam logic [STEP_BITS-1:0] RESET_STEP = 32'd42949673;

    localparam longint unsigned SIN_A    = 102944;
    localparam longint unsigned SIN_B    = 42047;
    localparam longint unsigned SIN_C    = 4640;
    localparam longint unsigned WAVE_ONE = 32768;

    typedef enum logic [1:0] {
        MODE_CONST   = 2'd0,
        MODE_SINE    = 2'd1,
        MODE_TRI     = 2'd2,
        MODE_UNKNOWN = 2'd3
    } t_mode;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_WAVE_MODE  = 3'd0,
        REG_LOW_LEVEL  = 3'd1,
        REG_HIGH_LEVEL = 3'd2,
        REG_PHASE_STEP = 3'd3,
        REG_HOLD_LEVEL = 3'd4
    } t_reg_idx;

    typedef struct packed {
        t_mode                         mode;
        logic signed [LEVEL_BITS-1:0]  low;
        logic signed [LEVEL_BITS-1:0]  high;
        logic [STEP_BITS-1:0]          step;
        logic signed [LEVEL_BITS-1:0]  hold;
    } t_cfg;

    // Shared pipeline control: every stage moves when adv is high.
    typedef struct packed {
        logic adv;
    } t_pipe_ctl;

    typedef logic [WAVE_BITS-2:0] t_rom_word;
    typedef t_rom_word t_sine_rom [0:SINE_N];

    // Quarter-wave table, polynomial sine in Q0.16 rounded to Q1.15.
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned inner;
        longint unsigned p;
        longint unsigned y;
        longint unsigned q;
        for (int k = 0; k <= SINE_N; k++) begin
            x     = 64'(k) << (16 - TBL_ADDR_BITS);
            x2    = (x * x) >> 16;
            inner = SIN_B - ((x2 * SIN_C) >> 16);
            p     = SIN_A - ((x2 * inner) >> 16);
            y     = (x * p) >> 16;
            q     = (y + 1) >> 1;
            if (q > WAVE_ONE) begin
                q = WAVE_ONE;
            end
            rom[k] = t_rom_word'(q);
        end
        return rom;
    endfunction

endpackage

// ----- src/swg_phase.sv -----
// Phase accumulator and first pipeline stage of the waveform generator.
// Depends on swg_pkg.
module swg_phase (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  swg_pkg::t_pipe_ctl              i_ctl,
    input  swg_pkg::t_cfg                   i_cfg,
    input  logic                            i_accept,
    input  logic                            i_restart,
    output logic                            o_valid,
    output logic [swg_pkg::TOP_BITS-1:0]    o_phase_top
);

    logic [swg_pkg::PHASE_BITS-1:0] r_phase;
    logic [swg_pkg::PHASE_BITS-1:0] n_cur;
    logic                           r_valid;
    logic [swg_pkg::TOP_BITS-1:0]   r_phase_top;

    // A restart zeroes the phase used by this very item.
    assign n_cur = i_restart ? '0 : r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_phase <= n_cur + swg_pkg::PHASE_BITS'(i_cfg.step);
            end
            if (i_ctl.adv) begin
                r_valid <= i_accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_phase_top <= n_cur[swg_pkg::PHASE_BITS-1 -: swg_pkg::TOP_BITS];
        end
    end

    assign o_valid     = r_valid;
    assign o_phase_top = r_phase_top;

endmodule

// ----- src/swg_wave.sv -----
// Wave shaping stage: quarter-wave sine ROM read and triangle fold.
// Depends on swg_pkg.
module swg_wave (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  swg_pkg::t_pipe_ctl                    i_ctl,
    input  logic                                  i_valid,
    input  logic [swg_pkg::TOP_BITS-1:0]          i_phase_top,
    output logic                                  o_valid,
    output swg_pkg::t_rom_word                    o_sine_mag,
    output logic                                  o_sine_neg,
    output logic signed [swg_pkg::WAVE_BITS-1:0]  o_tri
);

    localparam swg_pkg::t_sine_rom SINE_ROM = swg_pkg::build_sine_rom();

    logic [swg_pkg::TBL_ADDR_BITS-1:0]     w_idx;
    logic [1:0]                            w_quad;
    logic [swg_pkg::TBL_ADDR_BITS:0]       w_addr;
    logic signed [swg_pkg::TOP_BITS-1:0]   w_s;
    logic [swg_pkg::TOP_BITS:0]            w_abs;
    logic [swg_pkg::TOP_BITS+1:0]          w_tri_wide;

    logic                                  r_valid;
    swg_pkg::t_rom_word                    r_sine_mag;
    logic                                  r_sine_neg;
    logic signed [swg_pkg::WAVE_BITS-1:0]  r_tri;

    assign w_quad = i_phase_top[swg_pkg::TOP_BITS-1 -: 2];
    assign w_idx  = i_phase_top[swg_pkg::TOP_BITS-3 -: swg_pkg::TBL_ADDR_BITS];

    // Odd quadrants run the table backwards.
    assign w_addr = w_quad[0]
                  ? ((swg_pkg::TBL_ADDR_BITS+1)'(swg_pkg::SINE_N) - {1'b0, w_idx})
                  : {1'b0, w_idx};

    // Triangle: 2*|s| - 1.0, with s the top phase bits read as signed.
    assign w_s        = $signed(i_phase_top);
    assign w_abs      = w_s[swg_pkg::TOP_BITS-1]
                      ? (swg_pkg::TOP_BITS+1)'(-{w_s[swg_pkg::TOP_BITS-1], w_s})
                      : {1'b0, i_phase_top};
    assign w_tri_wide = {w_abs, 1'b0} - (swg_pkg::TOP_BITS+2)'(swg_pkg::WAVE_ONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_sine_mag <= SINE_ROM[w_addr];
            r_sine_neg <= w_quad[1];
            r_tri      <= $signed(w_tri_wide[swg_pkg::WAVE_BITS-1:0]);
        end
    end

    assign o_valid    = r_valid;
    assign o_sine_mag = r_sine_mag;
    assign o_sine_neg = r_sine_neg;
    assign o_tri      = r_tri;

endmodule

// ----- src/swg_scale.sv -----
// Scaling stages: wave times swing, then centering, rounding and saturation (or the
// hold level in constant mode) into the output register. Depends on swg_pkg.
module swg_scale (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  swg_pkg::t_pipe_ctl                    i_ctl,
    input  swg_pkg::t_cfg                         i_cfg,
    input  logic                                  i_valid,
    input  swg_pkg::t_rom_word                    i_sine_mag,
    input  logic                                  i_sine_neg,
    input  logic signed [swg_pkg::WAVE_BITS-1:0]  i_tri,
    output logic                                  o_valid,
    output logic signed [swg_pkg::LEVEL_BITS-1:0] o_level,
    output logic                                  o_mode_error
);

    localparam int DIFF_BITS = swg_pkg::LEVEL_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + swg_pkg::WAVE_BITS;
    localparam int NUM_BITS  = PROD_BITS + 2;
    localparam int RES_BITS  = NUM_BITS - 16;

    localparam logic signed [RES_BITS-1:0] LVL_MAX =
        RES_BITS'((64'sd1 <<< (swg_pkg::LEVEL_BITS - 1)) - 64'sd1);
    localparam logic signed [RES_BITS-1:0] LVL_MIN =
        RES_BITS'(-(64'sd1 <<< (swg_pkg::LEVEL_BITS - 1)));

    logic signed [swg_pkg::WAVE_BITS-1:0] w_sine;
    logic signed [swg_pkg::WAVE_BITS-1:0] w_wave;
    logic signed [DIFF_BITS-1:0]          w_diff;
    logic signed [DIFF_BITS-1:0]          w_sum;
    logic signed [NUM_BITS-1:0]           w_num;
    logic signed [RES_BITS-1:0]           w_res;
    logic signed [swg_pkg::LEVEL_BITS-1:0] w_swing;
    logic signed [swg_pkg::LEVEL_BITS-1:0] n_level;
    logic                                 n_err;

    logic                                 r_valid3;
    logic signed [PROD_BITS-1:0]          r_prod;
    logic                                 r_valid;
    logic signed [swg_pkg::LEVEL_BITS-1:0] r_level;
    logic                                 r_err;

    assign w_sine = i_sine_neg ? -$signed({1'b0, i_sine_mag}) : $signed({1'b0, i_sine_mag});
    assign w_wave = (i_cfg.mode == swg_pkg::MODE_TRI) ? i_tri : w_sine;
    assign w_diff = DIFF_BITS'(i_cfg.high) - DIFF_BITS'(i_cfg.low);
    assign w_sum  = DIFF_BITS'(i_cfg.high) + DIFF_BITS'(i_cfg.low);

    // Level = floor(((hi+lo)*2^15 + (hi-lo)*wave + 2^15) / 2^16).
    assign w_num = (NUM_BITS'(w_sum) <<< 15) + NUM_BITS'(r_prod) + NUM_BITS'(32768);
    assign w_res = w_num[NUM_BITS-1:16];

    always_comb begin
        if (w_res > LVL_MAX) begin
            w_swing = LVL_MAX[swg_pkg::LEVEL_BITS-1:0];
        end else if (w_res < LVL_MIN) begin
            w_swing = LVL_MIN[swg_pkg::LEVEL_BITS-1:0];
        end else begin
            w_swing = w_res[swg_pkg::LEVEL_BITS-1:0];
        end
    end

    always_comb begin
        n_err = 1'b0;
        unique case (i_cfg.mode)
            swg_pkg::MODE_CONST: begin
                n_level = i_cfg.hold;
            end
            swg_pkg::MODE_SINE, swg_pkg::MODE_TRI: begin
                n_level = w_swing;
            end
            default: begin
                n_level = '0;
                n_err   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid3 <= 1'b0;
            r_valid  <= 1'b0;
        end else if (i_ctl.adv) begin
            r_valid3 <= i_valid;
            r_valid  <= r_valid3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_prod  <= w_diff * w_wave;
            r_level <= n_level;
            r_err   <= n_err;
        end
    end

    assign o_valid      = r_valid;
    assign o_level      = r_level;
    assign o_mode_error = r_err;

endmodule

// ----- src/sine_triangle_waveform_generator.sv -----
// Channel     | Dir | Handshake                  | Payload
// s_axis      | in  | i_s_axis_tvalid/o_..tready | tdata[0] restart
// m_axis      | out | o_m_axis_tvalid/i_..tready | tdata level, tuser mode_error
// cfg         | in  | i_cfg_we (no wait)         | i_cfg_addr index, i_cfg_wdata value
// One item per cycle is accepted while the pipeline moves; each result passes
// through the four register stages (phase, ROM read, multiply, round/saturate).
// All stages move together and stop only while a finished result is not taken.
// Synchronous active-low reset clears the phase, the valid flags and the
// config registers to their defaults. Top level; depends on swg_pkg and submodules.
module sine_triangle_waveform_generator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [7:0]                           i_s_axis_tdata,   // [0] restart
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [swg_pkg::LEVEL_BITS-1:0]       o_m_axis_tdata,   // level
    output logic                                 o_m_axis_tuser,   // [0] mode_error
    input  logic                                 i_cfg_we,
    input  logic [swg_pkg::CFG_ADDR_BITS-1:0]    i_cfg_addr,
    input  logic [swg_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata
);

    swg_pkg::t_cfg                          r_cfg;
    swg_pkg::t_pipe_ctl                     w_ctl;
    logic                                   w_accept;
    logic                                   w_v1;
    logic [swg_pkg::TOP_BITS-1:0]           w_phase_top;
    logic                                   w_v2;
    swg_pkg::t_rom_word                     w_sine_mag;
    logic                                   w_sine_neg;
    logic signed [swg_pkg::WAVE_BITS-1:0]   w_tri;
    logic signed [swg_pkg::LEVEL_BITS-1:0]  w_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= swg_pkg::MODE_CONST;
            r_cfg.low  <= '0;
            r_cfg.high <= '0;
            r_cfg.step <= swg_pkg::RESET_STEP;
            r_cfg.hold <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                swg_pkg::REG_WAVE_MODE:  r_cfg.mode <= swg_pkg::t_mode'(i_cfg_wdata[1:0]);
                swg_pkg::REG_LOW_LEVEL:  r_cfg.low  <= i_cfg_wdata[swg_pkg::LEVEL_BITS-1:0];
                swg_pkg::REG_HIGH_LEVEL: r_cfg.high <= i_cfg_wdata[swg_pkg::LEVEL_BITS-1:0];
                swg_pkg::REG_PHASE_STEP: r_cfg.step <= i_cfg_wdata[swg_pkg::STEP_BITS-1:0];
                swg_pkg::REG_HOLD_LEVEL: r_cfg.hold <= i_cfg_wdata[swg_pkg::LEVEL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_ctl.adv       = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_ctl.adv;
    assign w_accept        = i_s_axis_tvalid && w_ctl.adv;

    swg_phase u_phase (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_cfg       (r_cfg),
        .i_accept    (w_accept),
        .i_restart   (i_s_axis_tdata[0]),
        .o_valid     (w_v1),
        .o_phase_top (w_phase_top)
    );

    swg_wave u_wave (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_valid     (w_v1),
        .i_phase_top (w_phase_top),
        .o_valid     (w_v2),
        .o_sine_mag  (w_sine_mag),
        .o_sine_neg  (w_sine_neg),
        .o_tri       (w_tri)
    );

    swg_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_cfg        (r_cfg),
        .i_valid      (w_v2),
        .i_sine_mag   (w_sine_mag),
        .i_sine_neg   (w_sine_neg),
        .i_tri        (w_tri),
        .o_valid      (o_m_axis_tvalid),
        .o_level      (w_level),
        .o_mode_error (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = w_level;

    // A flagged result always carries a zero level.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("mode error with nonzero level");

    // A restarting item enters the pipeline with phase zero.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_s_axis_tdata[0] |=> w_v1 && w_phase_top == '0)
        else $error("restart did not clear phase");

    // An item accepted while the pipeline moves shows up in the first stage.
    a_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.adv |=> w_v1 == $past(w_accept))
        else $error("first stage valid lost or invented");

endmodule
